// ===== rtl/bta_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the block table first-fit allocator.
// No dependencies; every other file of the block imports this package.
package bta_pkg;

	// Operation codes carried in the request.
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic        func;
		logic [31:0] size_bytes;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] alloc_address;
		logic [1:0]  status;
	} rsp_t;

	// One table entry. A block is free when its taken flag is clear.
	typedef struct packed {
		logic has_next;
		logic first;
		logic taken;
	} flags_t;

endpackage

// ===== rtl/block_table_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Allocate scans the table up to the first fit, at most NUM_BLOCKS blocks, then marks the run.
// Free steps block by block to the block holding the address, then releases its run.
// Zero-size and out-of-heap requests are answered from idle; results are registered and appear the cycle after.
// Reset clears the table in a pass over all NUM_BLOCKS entries with busy high.
// Results cannot be stalled; done pulses for one cycle per request.
module block_table_first_fit_allocator #(
	parameter int NUM_BLOCKS  = 256,
	parameter int BLOCK_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bta_pkg::req_t  req,
	output logic           done,
	output bta_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_data
);
	import bta_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	logic [31:0]      heap_base_q;
	logic             fin;
	rsp_t             res;
	logic             done_q;
	rsp_t             rsp_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	flags_t           mem_wdata, mem_rdata;

	// The base may only change while no request is being worked on.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				heap_base_q <= cfg_data;
			end
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= res;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	bta_ctrl #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.heap_base (heap_base_q),
		.busy      (busy),
		.fin       (fin),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bta_table #(
		.DEPTH  (NUM_BLOCKS),
		.ADDR_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== rtl/bta_table.sv =====
`timescale 1ns / 1ps
// Block flag table: single write port, single registered read port.
// Depends on bta_pkg for the entry type.
module bta_table #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  bta_pkg::flags_t    wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output bta_pkg::flags_t    rdata
);
	import bta_pkg::*;

	flags_t mem [DEPTH];
	flags_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bta_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the allocator: clearing pass, first-fit scan, run marking,
// address-to-block stepping and run release. Depends on bta_pkg and drives bta_table.
module bta_ctrl #(
	parameter int NUM_BLOCKS  = 256,
	parameter int BLOCK_BYTES = 4096,
	parameter int IDX_W       = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bta_pkg::req_t      req,
	input  logic [31:0]        heap_base,
	output logic               busy,
	output logic               fin,
	output bta_pkg::rsp_t      res,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output bta_pkg::flags_t    mem_wdata,
	output logic [IDX_W-1:0]   mem_raddr,
	input  bta_pkg::flags_t    mem_rdata
);
	import bta_pkg::*;

	localparam longint unsigned HEAP_BYTES = 64'(NUM_BLOCKS) * 64'(BLOCK_BYTES);
	localparam int HB_W  = $clog2(HEAP_BYTES + 64'd1);
	localparam int OFF_W = (HB_W > 32) ? HB_W : 32;
	localparam logic [OFF_W-1:0] HEAP_LIM = OFF_W'(HEAP_BYTES);
	localparam logic [OFF_W-1:0] BLK_INC  = OFF_W'(BLOCK_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_MARK  = 6'b001000,
		S_DIV   = 6'b010000,
		S_WALK  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [IDX_W-1:0]   first_q, end_q;
	logic [OFF_W-1:0]   off_q, off_d;
	logic [OFF_W-1:0]   run_q, run_d;
	logic [OFF_W-1:0]   first_off_q;
	logic [31:0]        target_q;

	logic [OFF_W-1:0]   off_inc, run_inc, target_ext;
	logic [IDX_W-1:0]   idx_inc;
	logic               last;
	logic [32:0]        diff;
	logic               free_bad;
	logic               take_first, fit_now, accept;

	assign off_inc    = off_q + BLK_INC;
	assign run_inc    = run_q + BLK_INC;
	assign target_ext = OFF_W'(target_q);
	assign idx_inc    = idx_q + IDX_W'(1);
	assign last       = (idx_q == LAST_IDX);

	// A free address below the base borrows out of the 33-bit difference.
	assign diff     = {1'b0, req.free_address} - {1'b0, heap_base};
	assign free_bad = diff[32] || (OFF_W'(diff[31:0]) >= HEAP_LIM);

	assign busy       = (state_q != S_IDLE);
	assign accept     = (state_q == S_IDLE) && start;
	assign take_first = (run_q == '0);
	// The run fits once its byte length covers the request, which is the
	// rounded-up block count reached exactly.
	assign fit_now    = !mem_rdata.taken && (run_inc >= target_ext);

	always_comb begin
		state_d           = state_q;
		idx_d             = idx_q;
		off_d             = off_q;
		run_d             = run_q;
		fin               = 1'b0;
		res.alloc_address = '0;
		res.status        = ST_OK;
		mem_we            = 1'b0;
		mem_waddr         = idx_q;
		mem_wdata         = '0;
		mem_raddr         = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				idx_d  = idx_inc;
				if (last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				idx_d = '0;
				off_d = '0;
				run_d = '0;
				if (start) begin
					if (req.func == FUNC_ALLOC) begin
						if (req.size_bytes == '0) begin
							fin        = 1'b1;
							res.status = ST_NOFIT;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						if (free_bad) begin
							fin        = 1'b1;
							res.status = ST_RANGE;
						end else begin
							state_d = S_DIV;
						end
					end
				end
			end
			S_SCAN: begin
				mem_raddr = idx_inc;
				idx_d     = idx_inc;
				off_d     = off_inc;
				run_d     = mem_rdata.taken ? '0 : run_inc;
				if (fit_now) begin
					state_d = S_MARK;
					idx_d   = take_first ? idx_q : first_q;
				end else if (last) begin
					fin        = 1'b1;
					res.status = ST_NOFIT;
					state_d    = S_IDLE;
				end
			end
			S_MARK: begin
				mem_we             = 1'b1;
				mem_wdata.taken    = 1'b1;
				mem_wdata.first    = (idx_q == first_q);
				mem_wdata.has_next = (idx_q != end_q);
				idx_d              = idx_inc;
				if (idx_q == end_q) begin
					fin               = 1'b1;
					res.alloc_address = heap_base + first_off_q[31:0];
					state_d           = S_IDLE;
				end
			end
			S_DIV: begin
				// Step block by block until the next block would pass the offset.
				mem_raddr = idx_q;
				if (off_inc <= target_ext) begin
					off_d = off_inc;
					idx_d = idx_inc;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				mem_we    = 1'b1;
				mem_raddr = idx_inc;
				if (mem_rdata.has_next && !last) begin
					idx_d = idx_inc;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d;
		run_q <= run_d;
		if (accept) begin
			target_q <= (req.func == FUNC_ALLOC) ? req.size_bytes : diff[31:0];
		end
		if (state_q == S_SCAN) begin
			if (!mem_rdata.taken && take_first) begin
				first_q     <= idx_q;
				first_off_q <= off_q;
			end
			if (fit_now) begin
				end_q <= idx_q;
			end
		end
	end

endmodule

// ===== rtl/bta_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the allocator, bound to the top level.
// Depends on bta_pkg for the result type and status codes.
module bta_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input bta_pkg::rsp_t rsp
);
	import bta_pkg::*;

	// A result only follows work in progress or a transfer in the cycle before.
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a request in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_NOFIT || rsp.status == ST_RANGE))
		else $error("undefined status code");

	// Every failure reports a zero address.
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.alloc_address == '0))
		else $error("failed request returned a nonzero address");

	// The table clearing pass keeps the block busy right after reset.
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("not busy during the clearing pass");

endmodule

bind block_table_first_fit_allocator bta_checker u_chk (.*);
